// ===== rtl/vfc_pkg.sv =====
package vfc_pkg;

	localparam int NUM_PLANES = 6;
	localparam int NUM_REGS   = 8;
	localparam int COEF_W     = 34;
	localparam int MEM_W      = 48;
	localparam int MEM_DEPTH  = 4 * NUM_PLANES;
	localparam int SMUL_W     = 66;

	localparam logic [1:0] KIND_SPHERE = 2'd1;
	localparam logic [1:0] KIND_BOX    = 2'd2;

	typedef struct packed {
		logic busy;
		logic done;
	} smul_sts_t;

endpackage

// ===== rtl/vfc_serial_mul.sv =====
module vfc_serial_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [vfc_pkg::SMUL_W-1:0]   a,
	input  logic [vfc_pkg::SMUL_W-1:0]   b,
	output vfc_pkg::smul_sts_t           sts,
	output logic [2*vfc_pkg::SMUL_W-1:0] p
);
	import vfc_pkg::*;

	localparam int CNT_W = $clog2(SMUL_W + 1);

	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [SMUL_W-1:0]   a_q;
	logic [2*SMUL_W-1:0] p_q;
	logic [SMUL_W:0]     sum;

	// shift-add, one multiplier bit per cycle
	assign sum = {1'b0, p_q[2*SMUL_W-1:SMUL_W]} + (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SMUL_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{SMUL_W{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[SMUL_W-1:1]};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign p        = p_q;

endmodule

// ===== rtl/view_frustum_culling_test.sv =====
// Channel | Dir | Handshake             | Payload
// s_*     | in  | s_tvalid / s_tready   | tuser: kind; tdata: query geometry
// m_*     | out | m_tvalid / m_tready   | tdata[0]: inside_res
// cfg_*   | in  | cfg_valid / cfg_ready | cfg_index, cfg_data (matrix rows)
//
// One query at a time. Each plane is read from the plane RAM, run as dot
// product steps through the shared 33x33 multiplier, then decided; a sphere
// whose center distance is negative goes on through the bit-serial wide
// multiplier (S^2 and r^2*L^2). The first query after reset or a matrix
// write first rebuilds the plane RAM. Results wait in an output register; a
// new query is accepted while it waits. Reset clears the matrix to zero and
// marks planes stale.
module view_frustum_culling_test #(
	parameter int COORD_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pos_x[31:0], pos_y[63:32], pos_z[95:64], radius[126:96],
	// box_max_x[158:127], box_max_y[190:159], box_max_z[222:191], pad[223]
	input  logic [223:0] s_tdata,
	// kind[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// inside_res[0], pad[7:1]
	output logic [7:0]   m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [3:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	import vfc_pkg::*;

	localparam int SH = 32 - COORD_WIDTH;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_BUILD = 4'd1;
	localparam logic [3:0] ST_LOAD  = 4'd2;
	localparam logic [3:0] ST_DOT   = 4'd3;
	localparam logic [3:0] ST_CHECK = 4'd4;
	localparam logic [3:0] ST_SQ    = 4'd5;
	localparam logic [3:0] ST_MUL1  = 4'd6;
	localparam logic [3:0] ST_MUL2  = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	// control
	logic [3:0]   state_q;
	logic [2:0]   cnt_q;
	logic [4:0]   bcnt_q;
	logic [2:0]   plane_q;
	logic         planes_valid_q;
	logic         m_valid_q;
	logic         inside_q;
	logic         result_q;
	logic [127:0] row_q [4];

	// query and datapath
	logic [1:0]               kind_q;
	logic signed [31:0]       lo_q [3];
	logic signed [31:0]       hi_q [3];
	logic [30:0]              rad_q;
	logic signed [COEF_W-1:0] coef_q [4];
	logic [65:0]              prod_q;
	logic                     prod_neg_q;
	logic signed [67:0]       acc_q;
	logic [65:0]              l2_q;
	logic [65:0]              r2_q;
	logic [131:0]             s2_q;

	// plane RAM: a,b,c,d per plane, one synchronous read port
	logic [MEM_W-1:0] mem [MEM_DEPTH];
	logic [MEM_W-1:0] mem_rdata_q;
	logic [4:0]       rd_addr;
	logic [MEM_W-1:0] wr_data;

	logic                     acc_in;
	logic [1:0]               kk;
	logic [1:0]               ci;
	logic signed [COEF_W-1:0] coef_k;
	logic [32:0]              coef_mag;
	logic signed [31:0]       coord_k;
	logic [31:0]              coord_mag;
	logic [32:0]              mul_a;
	logic [32:0]              mul_b;
	logic [65:0]              mul_p;
	logic signed [67:0]       prod_s;
	logic                     zero_normal;
	logic                     last_plane;

	// rebuild path
	logic [2:0]         b_plane;
	logic [1:0]         b_row;
	logic [1:0]         b_col;
	logic [127:0]       b_rowv;
	logic signed [31:0] b_base;
	logic signed [31:0] b_other;
	logic signed [COEF_W-1:0] b_val;

	logic               smul_start;
	logic [SMUL_W-1:0]  smul_a;
	logic [SMUL_W-1:0]  smul_b;
	smul_sts_t          smul_sts;
	logic [2*SMUL_W-1:0] smul_p;
	logic [SMUL_W-1:0]  s_mag;

	assign s_tready  = (state_q == ST_IDLE);
	assign acc_in    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = {7'd0, inside_q};

	// plane build: col = plane/2, odd planes subtract
	assign b_plane = bcnt_q[4:2];
	assign b_row   = bcnt_q[1:0];
	assign b_col   = b_plane[2:1];
	assign b_rowv  = row_q[b_row];
	assign b_base  = signed'(b_rowv[127:96]);
	assign b_other = signed'(b_rowv[32*b_col +: 32]);
	assign b_val   = b_plane[0] ? (COEF_W'(b_base) - COEF_W'(b_other))
	                            : (COEF_W'(b_base) + COEF_W'(b_other));
	assign wr_data = MEM_W'(b_val);

	assign rd_addr = {plane_q, cnt_q[1:0]};

	always_ff @(posedge clk) begin
		if (state_q == ST_BUILD)
			mem[bcnt_q] <= wr_data;
		mem_rdata_q <= mem[rd_addr];
	end

	// shared multiplier operands
	assign kk        = cnt_q[1:0];
	assign ci        = (kk == 2'd3) ? 2'd0 : kk;
	assign coef_k    = coef_q[kk];
	assign coef_mag  = coef_k[COEF_W-1] ? 33'(-coef_k) : 33'(coef_k);
	assign coord_k   = (kind_q == KIND_BOX && !coef_k[COEF_W-1]) ? hi_q[ci] : lo_q[ci];
	assign coord_mag = coord_k[31] ? 32'(-{coord_k[31], coord_k}) : 32'(coord_k);

	always_comb begin
		mul_a = coef_mag;
		mul_b = {1'b0, coord_mag};
		if (state_q == ST_SQ) begin
			if (kk == 2'd3) begin
				mul_a = {2'b00, rad_q};
				mul_b = {2'b00, rad_q};
			end else begin
				mul_b = coef_mag;
			end
		end
	end

	assign mul_p  = mul_a * mul_b;
	assign prod_s = prod_neg_q ? -signed'({2'b00, prod_q}) : signed'({2'b00, prod_q});

	assign zero_normal = (coef_q[0] == '0) && (coef_q[1] == '0) && (coef_q[2] == '0);
	assign last_plane  = (plane_q == 3'(NUM_PLANES - 1));
	assign s_mag       = SMUL_W'(-acc_q);

	assign smul_start = ((state_q == ST_SQ) && (cnt_q == 3'd4)) ||
	                    ((state_q == ST_MUL1) && smul_sts.done);
	assign smul_a     = (state_q == ST_MUL1) ? r2_q : s_mag;
	assign smul_b     = (state_q == ST_MUL1) ? l2_q : s_mag;

	vfc_serial_mul u_smul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (smul_start),
		.a      (smul_a),
		.b      (smul_b),
		.sts    (smul_sts),
		.p      (smul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			bcnt_q         <= '0;
			plane_q        <= '0;
			planes_valid_q <= 1'b0;
			m_valid_q      <= 1'b0;
			inside_q       <= 1'b0;
			result_q       <= 1'b0;
			for (int i = 0; i < 4; i++)
				row_q[i] <= '0;
		end else begin
			if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cnt_q   <= '0;
						bcnt_q  <= '0;
						plane_q <= '0;
						state_q <= planes_valid_q ? ST_LOAD : ST_BUILD;
					end
				end
				ST_BUILD: begin
					bcnt_q <= bcnt_q + 1'b1;
					if (bcnt_q == 5'(MEM_DEPTH - 1)) begin
						planes_valid_q <= 1'b1;
						state_q        <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 3'd4) begin
						cnt_q   <= '0;
						state_q <= ST_DOT;
					end
				end
				ST_DOT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 3'd3)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					cnt_q <= '0;
					if (zero_normal || !acc_q[67]) begin
						if (last_plane) begin
							result_q <= 1'b1;
							state_q  <= ST_DONE;
						end else begin
							plane_q <= plane_q + 1'b1;
							state_q <= ST_LOAD;
						end
					end else if (kind_q != KIND_SPHERE) begin
						result_q <= 1'b0;
						state_q  <= ST_DONE;
					end else begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 3'd4)
						state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					if (smul_sts.done)
						state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					if (smul_sts.done) begin
						cnt_q <= '0;
						// sphere rejects when r*L < |S|
						if (smul_p < s2_q) begin
							result_q <= 1'b0;
							state_q  <= ST_DONE;
						end else if (last_plane) begin
							result_q <= 1'b1;
							state_q  <= ST_DONE;
						end else begin
							plane_q <= plane_q + 1'b1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						inside_q  <= result_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// matrix write; index beyond the list is dropped
			if (cfg_valid && !cfg_index[3]) begin
				row_q[cfg_index[2:1]][64*cfg_index[0] +: 64] <= cfg_data;
				planes_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			kind_q  <= s_tuser;
			lo_q[0] <= signed'(s_tdata[31:0]   << SH) >>> SH;
			lo_q[1] <= signed'(s_tdata[63:32]  << SH) >>> SH;
			lo_q[2] <= signed'(s_tdata[95:64]  << SH) >>> SH;
			rad_q   <= s_tdata[126:96];
			hi_q[0] <= signed'(s_tdata[158:127] << SH) >>> SH;
			hi_q[1] <= signed'(s_tdata[190:159] << SH) >>> SH;
			hi_q[2] <= signed'(s_tdata[222:191] << SH) >>> SH;
		end
		case (state_q)
			ST_LOAD: begin
				if (cnt_q != 3'd0)
					coef_q[2'(cnt_q - 3'd1)] <= signed'(mem_rdata_q[COEF_W-1:0]);
				// d term enters in Q32.32
				if (cnt_q == 3'd4)
					acc_q <= 68'(signed'(mem_rdata_q[COEF_W-1:0])) <<< 16;
			end
			ST_DOT: begin
				if (cnt_q != 3'd3) begin
					prod_q     <= mul_p;
					prod_neg_q <= coef_k[COEF_W-1] ^ coord_k[31];
				end
				if (cnt_q != 3'd0)
					acc_q <= acc_q + prod_s;
			end
			ST_CHECK: begin
				l2_q <= '0;
			end
			ST_SQ: begin
				if (cnt_q != 3'd4) begin
					prod_q     <= mul_p;
					prod_neg_q <= 1'b0;
				end
				if (cnt_q != 3'd0 && cnt_q != 3'd4)
					l2_q <= l2_q + prod_q;
				if (cnt_q == 3'd4)
					r2_q <= prod_q;
			end
			ST_MUL1: begin
				if (smul_sts.done)
					s2_q <= smul_p;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/vfc_checker.sv =====
module vfc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [223:0] s_tdata,
	input logic [1:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [7:0]   m_tdata,
	input logic         cfg_valid,
	input logic         cfg_ready,
	input logic [3:0]   cfg_index,
	input logic [63:0]  cfg_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped while stalled");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:1] == 7'd0)
		else $error("result padding not zero");

	a_one_query: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second query taken while busy");

	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##5 !s_tready)
		else $error("query finished too early");

endmodule

bind view_frustum_culling_test vfc_checker u_vfc_checker (.*);

// ===== sim/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import vfc_pkg::*;

	localparam logic [1:0] KIND_POINT  = 2'd0;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int         IDLE_PCT    = 27;
	localparam int         DRAIN_WAIT  = 40;

	// One culling query as it travels on the slave side.
	typedef struct {
		logic [1:0]         kind;
		logic signed [31:0] lo [3];
		logic [30:0]        rad;
		logic signed [31:0] hi [3];
	} query_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [223:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [7:0]   m_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [3:0]   cfg_index;
	logic [63:0]  cfg_data;

	view_frustum_culling_test dut (.*);

	// Testbench copy of the matrix registers
	logic [63:0] matrix_regs [NUM_REGS];
	// Queries waiting for the slave-side transaction, verdicts waiting for the master side
	query_t      pending_queries [$];
	logic        expected_verdicts [$];
	int          error_count;
	bit          no_idle;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Matrix entry M[row][col]: register row*2 + col/2, odd columns in the upper word
	function automatic logic signed [31:0] matrix_entry(int row, int col);
		logic [63:0] r;
		r = matrix_regs[row * 2 + col / 2];
		return (col % 2) ? r[63:32] : r[31:0];
	endfunction

	// Expected inside flag: every plane column3 +/- column c must not reject the query.
	function automatic logic frustum_verdict(query_t q);
		logic signed [33:0]  coef [4];
		logic signed [127:0] plane_dist;
		logic signed [127:0] c128;
		logic signed [127:0] x128;
		logic signed [33:0]  base;
		logic signed [33:0]  other;
		logic [255:0]        norm_sq;
		logic [255:0]        dist_sq;
		logic [255:0]        rad_term;
		logic [127:0]        dist_mag;
		int                  col;
		for (int p = 0; p < NUM_PLANES; p++) begin
			col = p / 2;
			for (int k = 0; k < 4; k++) begin
				base  = matrix_entry(k, 3);
				other = matrix_entry(k, col);
				coef[k] = (p % 2) ? base - other : base + other;
			end
			// zero normal: plane is skipped
			if (coef[0] == 0 && coef[1] == 0 && coef[2] == 0)
				continue;
			plane_dist = '0;
			norm_sq    = '0;
			for (int k = 0; k < 3; k++) begin
				c128 = coef[k];
				// box: farthest corner along the normal, inverted boxes taken as given
				if (q.kind == KIND_BOX && coef[k] >= 0)
					x128 = q.hi[k];
				else
					x128 = q.lo[k];
				plane_dist = plane_dist + c128 * x128;
				norm_sq    = norm_sq + 256'(c128 * c128);
			end
			c128 = coef[3];
			plane_dist = plane_dist + (c128 <<< 16);
			if (plane_dist >= 0)
				continue;
			if (q.kind != KIND_SPHERE)
				return 1'b0;
			dist_mag = -plane_dist;
			dist_sq  = 256'(dist_mag) * 256'(dist_mag);
			rad_term = 256'(q.rad) * 256'(q.rad) * norm_sq;
			if (rad_term < dist_sq)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [223:0] pack_query(query_t q);
		return {1'b0, q.hi[2], q.hi[1], q.hi[0], q.rad, q.lo[2], q.lo[1], q.lo[0]};
	endfunction

	function automatic bit idle_now();
		return !no_idle && ($urandom_range(99) < IDLE_PCT);
	endfunction

	// Slave-side driver: head of pending_queries is what s_tdata carries while valid.
	always @(posedge clk or negedge arst_n) begin
		query_t q;
		bit     fire;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= KIND_POINT;
		end else begin
			fire = s_tvalid && s_tready;
			if (fire) begin
				q = pending_queries.pop_front();
				expected_verdicts.push_back(frustum_verdict(q));
			end
			if (!s_tvalid || fire) begin
				if (pending_queries.size() > 0 && !idle_now()) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pack_query(pending_queries[0]);
					s_tuser  <= pending_queries[0].kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Master-side monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		logic want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_verdicts.size() == 0) begin
					$error("unexpected result transaction, inside_res=%0b", m_tdata[0]);
					error_count++;
				end else begin
					want = expected_verdicts.pop_front();
					if (m_tdata[0] !== want) begin
						$error("inside_res mismatch: expected %0b actual %0b", want, m_tdata[0]);
						error_count++;
					end
				end
			end
			m_tready <= !idle_now();
		end
	end

	task automatic write_reg(int index, logic [63:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index[3:0];
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		// indexes past the last register are dropped by the block
		if (index < NUM_REGS)
			matrix_regs[index] = value;
	endtask

	task automatic wait_drained();
		while (pending_queries.size() > 0 || expected_verdicts.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Writes a full matrix given as entries; rows are x, y, z, w components.
	task automatic load_matrix(logic [31:0] m [4][4]);
		for (int r = 0; r < 4; r++) begin
			write_reg(r * 2, {m[r][1], m[r][0]});
			write_reg(r * 2 + 1, {m[r][3], m[r][2]});
		end
	endtask

	// Scaled box frustum with some skew: planes +/-s*x + w >= 0 plus noise.
	task automatic load_box_frustum();
		logic [31:0] m [4][4];
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				m[r][c] = ($urandom_range(3) == 0) ? $urandom_range(0, 1 << 15) - (1 << 14) : 0;
		for (int k = 0; k < 3; k++)
			m[k][k] = $urandom_range(1 << 15, 4 << 16) * ($urandom_range(1) ? 1 : -1);
		m[3][3] = $urandom_range(1 << 16, 3 << 16);
		load_matrix(m);
	endtask

	task automatic load_random_matrix();
		logic [31:0] m [4][4];
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				case ($urandom_range(3))
					0: m[r][c] = 32'h8000_0000;
					1: m[r][c] = 32'h7fff_ffff;
					default: m[r][c] = $urandom;
				endcase
		load_matrix(m);
	endtask

	function automatic logic [31:0] near_coord();
		return $urandom_range(0, 6 << 16) - (3 << 16);
	endfunction

	function automatic logic [31:0] any_coord();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2, 3, 4: return $urandom;
			default: return near_coord();
		endcase
	endfunction

	function automatic query_t random_query();
		query_t q;
		q.kind = ($urandom_range(19) == 0) ? KIND_UNUSED : 2'($urandom_range(2));
		for (int k = 0; k < 3; k++) begin
			q.lo[k] = any_coord();
			// mostly well-formed boxes, some inverted
			if ($urandom_range(4) == 0)
				q.hi[k] = any_coord();
			else
				q.hi[k] = q.lo[k] + $urandom_range(0, 2 << 16);
		end
		case ($urandom_range(5))
			0: q.rad = 31'($urandom);
			1: q.rad = 31'h7fff_ffff;
			default: q.rad = 31'($urandom_range(0, 2 << 16));
		endcase
		return q;
	endfunction

	task automatic push_query(logic [1:0] kind, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [30:0] rad, logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
		query_t q;
		q.kind  = kind;
		q.lo[0] = x;
		q.lo[1] = y;
		q.lo[2] = z;
		q.rad   = rad;
		q.hi[0] = bx;
		q.hi[1] = by;
		q.hi[2] = bz;
		pending_queries.push_back(q);
	endtask

	initial begin
		logic [31:0] id [4][4];
		error_count = 0;
		no_idle     = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		for (int i = 0; i < NUM_REGS; i++)
			matrix_regs[i] = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset matrix is all zero: every plane has a zero normal, all inside.
		push_query(KIND_POINT, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0, 0);
		push_query(KIND_SPHERE, 0, 0, 0, 31'h7fff_ffff, 0, 0, 0);
		wait_drained();

		// Unit box frustum: planes +/-x + 1 >= 0 etc.
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				id[r][c] = (r == c) ? 32'h0001_0000 : 32'h0;
		load_matrix(id);
		push_query(KIND_POINT, 0, 0, 0, 0, 0, 0, 0);
		push_query(KIND_POINT, 32'h0001_0000, 0, 0, 0, 0, 0, 0);
		push_query(KIND_POINT, 32'h0001_0001, 0, 0, 0, 0, 0, 0);
		push_query(KIND_POINT, 0, 0, 32'h8000_0000, 0, 0, 0, 0);
		push_query(KIND_POINT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0);
		// sphere just touching, just missing, far with huge radius, zero radius outside
		push_query(KIND_SPHERE, 32'h0002_0000, 0, 0, 31'h0001_0000, 0, 0, 0);
		push_query(KIND_SPHERE, 32'h0002_0001, 0, 0, 31'h0001_0000, 0, 0, 0);
		push_query(KIND_SPHERE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff,
			0, 0, 0);
		push_query(KIND_SPHERE, 32'h0005_0000, 0, 0, 0, 0, 0, 0);
		// box straddling the edge, outside, inverted, at the extremes
		push_query(KIND_BOX, 32'h0000_8000, 0, 0, 0, 32'h0004_0000, 0, 0);
		push_query(KIND_BOX, 32'h0002_0000, 0, 0, 0, 32'h0003_0000, 0, 0);
		push_query(KIND_BOX, 32'h0003_0000, 0, 0, 0, 32'hfffd_0000, 0, 0);
		push_query(KIND_BOX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		// unused kind acts as a point; radius and box fields ignored
		push_query(KIND_UNUSED, 32'h0003_0000, 0, 0, 31'h7fff_ffff, 0, 0, 0);
		push_query(KIND_POINT, 0, 0, 0, 31'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h1);
		wait_drained();

		// A write to an index past the last register changes nothing.
		write_reg(4'hf, 64'hffff_ffff_ffff_ffff);
		write_reg(NUM_REGS, 64'h8000_0000_8000_0000);
		push_query(KIND_POINT, 32'h0003_0000, 0, 0, 0, 0, 0, 0);
		push_query(KIND_POINT, 0, 0, 0, 0, 0, 0, 0);
		wait_drained();

		// Random phases, mostly structured frustums with random queries.
		for (int phase = 0; phase < 12; phase++) begin
			no_idle = (phase == 3);
			case (phase % 6)
				0: load_random_matrix();
				1: begin
					write_reg($urandom_range(NUM_REGS - 1), 64'h8000_0000_8000_0000);
					write_reg($urandom_range(NUM_REGS - 1), 64'h7fff_ffff_7fff_ffff);
				end
				default: load_box_frustum();
			endcase
			if ($urandom_range(1))
				write_reg($urandom_range(NUM_REGS, 15), $urandom);
			for (int i = 0; i < 118; i++)
				pending_queries.push_back(random_query());
			wait_drained();
		end

		// Back to all-zero, then all-ones matrices.
		for (int i = 0; i < NUM_REGS; i++)
			write_reg(i, 64'h0);
		for (int i = 0; i < 10; i++)
			pending_queries.push_back(random_query());
		wait_drained();
		for (int i = 0; i < NUM_REGS; i++)
			write_reg(i, 64'hffff_ffff_ffff_ffff);
		for (int i = 0; i < 10; i++)
			pending_queries.push_back(random_query());
		wait_drained();

		if (error_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		#50ms;
		$display("testbench: FAIL");
		$finish;
	end

endmodule
